>>> sv/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, masked while reset is high.
`define BSC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Concurrent check that also holds through reset.
`define BSC_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

>>> sv/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Types, codes and defaults shared by the safety check core and its checker.
// ----------------------------------------------------------------------------
package bsc_pkg;

   localparam int DEF_MAX_PROCS  = 8;
   localparam int DEF_MAX_RES    = 4;
   localparam int DEF_COUNT_BITS = 8;

   localparam int CSR_DATA_W = 4;
   localparam logic [3:0] NUM_PROCS_RST = 4'd8;
   localparam logic [2:0] NUM_RES_RST   = 3'd4;

   typedef enum logic [1:0] {
      OP_LOAD_ALLOC = 2'd0,
      OP_LOAD_MAX   = 2'd1,
      OP_LOAD_AVAIL = 2'd2,
      OP_REQUEST    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_GRANT  = 2'd0,
      STAT_EXCEED = 2'd1,
      STAT_WAIT   = 2'd2,
      STAT_UNSAFE = 2'd3
   } status_type;

   typedef enum logic {
      CSR_NUM_PROCS = 1'b0,
      CSR_NUM_RES   = 1'b1
   } csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_GRANT,
      ST_SCAN,
      ST_ROLLBACK,
      ST_REPLY,
      ST_EMIT
   } state_type;

endpackage

>>> sv/bsc_req_if.sv
// ----------------------------------------------------------------------------
// bsc_req_if
// Request channel: loads and request elements.
// ----------------------------------------------------------------------------
interface bsc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [2:0] process_index;
   logic [1:0] resource_index;
   logic [7:0] amount;
   logic       last_element;

   modport source (output valid, opcode, process_index, resource_index, amount,
                   last_element, input ready);
   modport sink   (input valid, opcode, process_index, resource_index, amount,
                   last_element, output ready);
endinterface

>>> sv/bsc_rsp_if.sv
// ----------------------------------------------------------------------------
// bsc_rsp_if
// Response channel: decision results.
// ----------------------------------------------------------------------------
interface bsc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [2:0] sequence_process;
   logic       last;

   modport source (output valid, status, sequence_process, last, input ready);
   modport sink   (input valid, status, sequence_process, last, output ready);
endinterface

>>> sv/bankers_safety_check_core.sv
// ----------------------------------------------------------------------------
// bankers_safety_check_core
// Banker's algorithm resource request engine with safety pass.
// ----------------------------------------------------------------------------
// Use:
//  req_ch transfers loads (allocation, maximum, available) and request
//  elements. A request element with last_element set starts a decision.
//  rsp_ch transfers the results: a safe grant gives one result per process
//  (num_procs held to 1..MAX_PROCS) carrying the safe sequence, every other
//  outcome gives one result with its status. The user must write num_procs
//  and num_res via csr_we/csr_index/csr_wdata only while idle; the block does
//  not enforce this. Loads are written as they are taken. Allocation and
//  maximum sit in two RAMs with registered read data; each resource step is
//  a read phase then a use/write phase. A decision runs the checks, the
//  tentative grant, scan rounds over the unfinished processes (finished ones
//  skipped), a rollback if unsafe, then the results, all bound by the single
//  read address shared by the two RAMs.
// Reset clears the controller, the output register, work and finished marks;
// matrix contents are undefined until loaded. A stalled rsp_ch holds its
// result; req_ch is only taken while the controller is idle.
// ----------------------------------------------------------------------------
module bankers_safety_check_core #(
   parameter int MAX_PROCS  = bsc_pkg::DEF_MAX_PROCS,
   parameter int MAX_RES    = bsc_pkg::DEF_MAX_RES,
   parameter int COUNT_BITS = bsc_pkg::DEF_COUNT_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   bsc_req_if.sink                        req_ch,
   bsc_rsp_if.source                      rsp_ch,
   input  logic                           csr_we,
   input  logic                           csr_index,
   input  logic [bsc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bsc_pkg::*;

   localparam int PB  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int RB  = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
   localparam int PCW = $clog2(MAX_PROCS + 1);
   localparam int RCW = $clog2(MAX_RES + 1);
   localparam int AW  = PB + RB;
   localparam int CB  = COUNT_BITS;
   localparam int WB  = COUNT_BITS + 4;

   // Configuration registers
   logic [3:0] num_procs_ff, num_procs_in;
   logic [2:0] num_res_ff, num_res_in;

   // Controller
   state_type  state_ff, state_in;
   logic       ph_ff, ph_in;               // 0: read issued, 1: data back
   logic [PB-1:0]  p_ff, p_in;             // requesting process
   logic [PB-1:0]  i_ff, i_in;             // scan process
   logic [RB-1:0]  j_ff, j_in;             // resource step
   logic [PCW-1:0] cnt_ff, cnt_in;         // processes finished
   logic           found_ff, found_in;
   logic [PB-1:0]  k_ff, k_in;             // emit position
   status_type     stat_ff, stat_in;

   // Vector state
   logic [CB-1:0] req_buf_ff [MAX_RES];
   logic [CB-1:0] req_buf_in [MAX_RES];
   logic [CB-1:0] avail_ff   [MAX_RES];
   logic [CB-1:0] avail_in   [MAX_RES];
   logic [WB-1:0] work_ff    [MAX_RES];
   logic [WB-1:0] work_in    [MAX_RES];
   logic [WB-1:0] tmp_ff     [MAX_RES];
   logic [WB-1:0] tmp_in     [MAX_RES];
   logic [MAX_PROCS-1:0] fin_ff, fin_in;
   logic [PB-1:0] seq_ff [MAX_PROCS];
   logic [PB-1:0] seq_in [MAX_PROCS];

   // Output register
   logic       out_valid_ff, out_valid_in;
   status_type out_stat_ff, out_stat_in;
   logic [2:0] out_seq_ff, out_seq_in;
   logic       out_last_ff, out_last_in;

   // RAM ports
   logic          alloc_we, max_we;
   logic [AW-1:0] alloc_waddr, max_waddr, raddr;
   logic [CB-1:0] alloc_wdata, max_wdata, rd_alloc, rd_max;

   // Derived
   logic [PCW-1:0] np;
   logic [RCW-1:0] nr;
   logic           accept, out_free, j_last, i_last, k_last;
   logic           p_ok, r_ok;
   logic [PB-1:0]  in_p;
   logic [RB-1:0]  in_r;
   logic [CB-1:0]  in_amt;
   logic [CB-1:0]  need, req_j;
   logic [WB:0]    sum_raw;
   logic [WB-1:0]  sum_sat;

   bsc_ram #(.AW(AW), .DW(CB)) u_alloc_ram (
      .clock (clock),
      .we    (alloc_we),
      .waddr (alloc_waddr),
      .wdata (alloc_wdata),
      .raddr (raddr),
      .rdata (rd_alloc)
   );

   bsc_ram #(.AW(AW), .DW(CB)) u_max_ram (
      .clock (clock),
      .we    (max_we),
      .waddr (max_waddr),
      .wdata (max_wdata),
      .raddr (raddr),
      .rdata (rd_max)
   );

   // Effective counts, saturated into range
   always_comb begin
      if (num_procs_ff == 4'd0) begin
         np = PCW'(1);
      end else if (32'(num_procs_ff) > MAX_PROCS) begin
         np = PCW'(MAX_PROCS);
      end else begin
         np = PCW'(num_procs_ff);
      end
      if (num_res_ff == 3'd0) begin
         nr = RCW'(1);
      end else if (32'(num_res_ff) > MAX_RES) begin
         nr = RCW'(MAX_RES);
      end else begin
         nr = RCW'(num_res_ff);
      end
   end

   assign accept   = req_ch.valid && req_ch.ready;
   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign j_last   = (RCW'(j_ff) + RCW'(1)) == nr;
   assign i_last   = (PCW'(i_ff) + PCW'(1)) == np;
   assign k_last   = (PCW'(k_ff) + PCW'(1)) == np;
   assign p_ok     = 32'(req_ch.process_index) < MAX_PROCS;
   assign r_ok     = 32'(req_ch.resource_index) < MAX_RES;
   assign in_p     = PB'(req_ch.process_index);
   assign in_r     = RB'(req_ch.resource_index);
   assign in_amt   = CB'(req_ch.amount);

   // Shared read address: requester row during check/grant/rollback
   assign raddr = (state_ff == ST_SCAN) ? {i_ff, j_ff} : {p_ff, j_ff};
   assign need  = (rd_max > rd_alloc) ? (rd_max - rd_alloc) : '0;
   assign req_j = req_buf_ff[j_ff];

   // Saturating work update for the scan
   assign sum_raw = {1'b0, work_ff[j_ff]} + (WB+1)'(rd_alloc);
   assign sum_sat = sum_raw[WB] ? '1 : sum_raw[WB-1:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_ch.opcode == OP_REQUEST && req_ch.last_element) begin
               if (PCW'(req_ch.process_index) >= np || !p_ok) begin
                  state_in = ST_REPLY;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (ph_ff) begin
               if (req_j > need || req_j > avail_ff[j_ff]) begin
                  state_in = ST_REPLY;
               end else if (j_last) begin
                  state_in = ST_GRANT;
               end
            end
         end
         ST_GRANT: begin
            if (ph_ff && j_last) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (i_last && (fin_ff[i_ff] || ph_ff && (need > work_ff[j_ff] || j_last))) begin
               if (cnt_in == np) begin
                  state_in = ST_EMIT;
               end else if (!found_ff && cnt_in == cnt_ff) begin
                  // nobody finished in this round
                  state_in = ST_ROLLBACK;
               end
            end
         end
         ST_ROLLBACK: begin
            if (ph_ff && j_last) begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (out_free && k_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      logic next_proc;
      next_proc = 1'b0;

      num_procs_in = num_procs_ff;
      num_res_in   = num_res_ff;
      ph_in    = 1'b0;
      p_in     = p_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      cnt_in   = cnt_ff;
      found_in = found_ff;
      k_in     = k_ff;
      stat_in  = stat_ff;
      req_buf_in = req_buf_ff;
      avail_in   = avail_ff;
      work_in    = work_ff;
      tmp_in     = tmp_ff;
      fin_in     = fin_ff;
      seq_in     = seq_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_stat_in  = out_stat_ff;
      out_seq_in   = out_seq_ff;
      out_last_in  = out_last_ff;
      alloc_we    = 1'b0;
      alloc_waddr = {in_p, in_r};
      alloc_wdata = in_amt;
      max_we      = 1'b0;
      max_waddr   = {in_p, in_r};
      max_wdata   = in_amt;

      if (csr_we) begin
         unique case (csr_type'(csr_index))
            CSR_NUM_PROCS: num_procs_in = csr_wdata;
            CSR_NUM_RES:   num_res_in   = csr_wdata[2:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (op_type'(req_ch.opcode))
                  OP_LOAD_ALLOC: alloc_we = p_ok && r_ok;
                  OP_LOAD_MAX:   max_we   = p_ok && r_ok;
                  OP_LOAD_AVAIL: begin
                     if (r_ok) begin
                        avail_in[in_r] = in_amt;
                     end
                  end
                  default: begin
                     if (p_ok && r_ok) begin
                        req_buf_in[in_r] = in_amt;
                     end
                     p_in    = in_p;
                     j_in    = '0;
                     stat_in = STAT_EXCEED;
                  end
               endcase
            end
         end
         ST_CHECK: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               if (req_j > need) begin
                  stat_in = STAT_EXCEED;
               end else if (req_j > avail_ff[j_ff]) begin
                  stat_in = STAT_WAIT;
               end else begin
                  j_in = j_last ? '0 : j_ff + RB'(1);
               end
            end
         end
         ST_GRANT: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               alloc_we    = 1'b1;
               alloc_waddr = {p_ff, j_ff};
               alloc_wdata = rd_alloc + req_j;
               avail_in[j_ff] = avail_ff[j_ff] - req_j;
               work_in[j_ff]  = WB'(avail_ff[j_ff] - req_j);
               j_in = j_last ? '0 : j_ff + RB'(1);
               if (j_last) begin
                  i_in     = '0;
                  cnt_in   = '0;
                  found_in = 1'b0;
                  fin_in   = '0;
               end
            end
         end
         ST_SCAN: begin
            if (fin_ff[i_ff]) begin
               next_proc = 1'b1;
            end else begin
               ph_in = !ph_ff;
               if (ph_ff) begin
                  if (need > work_ff[j_ff]) begin
                     next_proc = 1'b1;
                  end else if (j_last) begin
                     // process fits: commit the accumulated work
                     for (int r = 0; r < MAX_RES; r++) begin
                        work_in[r] = tmp_ff[r];
                     end
                     work_in[j_ff]  = sum_sat;
                     fin_in[i_ff]   = 1'b1;
                     seq_in[cnt_ff[PB-1:0]] = i_ff;
                     cnt_in   = cnt_ff + PCW'(1);
                     found_in = 1'b1;
                     next_proc = 1'b1;
                  end else begin
                     tmp_in[j_ff] = sum_sat;
                     j_in = j_ff + RB'(1);
                  end
               end
            end
            if (next_proc) begin
               ph_in = 1'b0;
               j_in  = '0;
               if (i_last) begin
                  i_in = '0;
                  if (cnt_in != np && found_in) begin
                     found_in = 1'b0;
                  end
               end else begin
                  i_in = i_ff + PB'(1);
               end
               k_in = '0;
            end
         end
         ST_ROLLBACK: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               alloc_we    = 1'b1;
               alloc_waddr = {p_ff, j_ff};
               alloc_wdata = rd_alloc - req_j;
               avail_in[j_ff] = avail_ff[j_ff] + req_j;
               j_in = j_last ? '0 : j_ff + RB'(1);
               stat_in = STAT_UNSAFE;
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_stat_in  = stat_ff;
               out_seq_in   = 3'd0;
               out_last_in  = 1'b1;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_stat_in  = STAT_GRANT;
               out_seq_in   = 3'(seq_ff[k_ff]);
               out_last_in  = k_last;
               k_in = k_ff + PB'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ph_ff        <= 1'b0;
         num_procs_ff <= NUM_PROCS_RST;
         num_res_ff   <= NUM_RES_RST;
         out_valid_ff <= 1'b0;
         fin_ff       <= '0;
         for (int r = 0; r < MAX_RES; r++) begin
            work_ff[r] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         ph_ff        <= ph_in;
         num_procs_ff <= num_procs_in;
         num_res_ff   <= num_res_in;
         out_valid_ff <= out_valid_in;
         fin_ff       <= fin_in;
         work_ff      <= work_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff       <= p_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      cnt_ff     <= cnt_in;
      found_ff   <= found_in;
      k_ff       <= k_in;
      stat_ff    <= stat_in;
      req_buf_ff <= req_buf_in;
      avail_ff   <= avail_in;
      tmp_ff     <= tmp_in;
      seq_ff     <= seq_in;
      out_stat_ff <= out_stat_in;
      out_seq_ff  <= out_seq_in;
      out_last_ff <= out_last_in;
   end

   // Only loads and request elements are taken while idle
   assign req_ch.ready = (state_ff == ST_IDLE);

   assign rsp_ch.valid            = out_valid_ff;
   assign rsp_ch.status           = out_stat_ff;
   assign rsp_ch.sequence_process = out_seq_ff;
   assign rsp_ch.last             = out_last_ff;
endmodule

>>> sv/bsc_ram.sv
// ----------------------------------------------------------------------------
// bsc_ram
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bsc_ram #(
   parameter int AW = 5,
   parameter int DW = 8
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);
   logic [DW-1:0] mem [2**AW];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> sv/bsc_checker.sv
// ----------------------------------------------------------------------------
// bsc_checker
// Port-level checks on the safety check core, bound into the core module.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic [2:0] rsp_seq,
   input logic       rsp_last
);
   import bsc_pkg::*;

   `BSC_ASSERT(a_deny_single, clock, reset, rsp_valid && rsp_status != STAT_GRANT |-> rsp_last)
   `BSC_ASSERT(a_deny_seq_zero, clock, reset, rsp_valid && rsp_status != STAT_GRANT |-> rsp_seq == 3'd0)
   `BSC_ASSERT(a_busy_mid_seq, clock, reset, rsp_valid && !rsp_last |-> !req_ready)
   `BSC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `BSC_ASSERT_NR(a_reset_idle, clock, reset |=> !rsp_valid && req_ready)
endmodule

bind bankers_safety_check_core bsc_checker u_bsc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_status (rsp_ch.status),
   .rsp_seq    (rsp_ch.sequence_process),
   .rsp_last   (rsp_ch.last)
);

>>> dv/bankers_safety_check_core_test.sv
// ----------------------------------------------------------------------------
// bankers_safety_check_core_test
// Self-checking bench for the banker's safety check core: a directed table
// followed by random load/request traffic over several num_procs/num_res
// settings; results are compared with a local predictor or a row's outcome.
// ----------------------------------------------------------------------------
module bankers_safety_check_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bsc_pkg::*;

   localparam int NPROC = DEF_MAX_PROCS;
   localparam int NRES = DEF_MAX_RES;
   localparam int WORK_MAX = (1 << (DEF_COUNT_BITS + 4)) - 1;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      status_type status;
      logic [2:0] seq_proc;
      logic       last;
   } decision_t;

   typedef struct {
      op_type     op;
      int         proc;
      int         res;
      int         amt;
      bit         last;
      bit         typed;     // expected outcome written in the row
      status_type status;
   } stim_row_t;

   logic clock;
   logic reset;
   logic csr_we;
   csr_type csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bsc_req_if req_ch ();
   bsc_rsp_if rsp_ch ();

   bankers_safety_check_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor copy of the block state.
   int alloc_mat [NPROC][NRES];
   int max_mat [NPROC][NRES];
   int avail_vec [NRES];
   int req_vec [NRES];
   int cfg_procs = 8;
   int cfg_res = 4;

   decision_t pending_results [$];
   decision_t decision_out [$];
   int errors = 0;
   bit hold_off_req = 0;
   int unsigned cycles = 0;

   // ------------------------------------------------------------------------
   // Clock and timeout
   // ------------------------------------------------------------------------
   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t timeout after %0d cycles", $time, cycles);
         $display("FAIL bankers_safety_check_core");
         $finish;
      end
   end

   function automatic int eff_procs();
      return (cfg_procs < 1) ? 1 : (cfg_procs > NPROC) ? NPROC : cfg_procs;
   endfunction

   function automatic int eff_res();
      return (cfg_res < 1) ? 1 : (cfg_res > NRES) ? NRES : cfg_res;
   endfunction

   function automatic int need_of(int p, int r);
      return (max_mat[p][r] > alloc_mat[p][r]) ? max_mat[p][r] - alloc_mat[p][r] : 0;
   endfunction

   // Single-result outcome: status with seq 0, last set.
   function automatic decision_t lone(status_type st);
      decision_t d;
      d.status = st;
      d.seq_proc = '0;
      d.last = 1'b1;
      return d;
   endfunction

   // ------------------------------------------------------------------------
   // Predictor: runs the banker's decision and fills decision_out.
   // ------------------------------------------------------------------------
   task automatic run_decision(int p);
      int np, nr, count;
      int work [NRES];
      bit done [NPROC];
      int order [NPROC];
      bit found, fits;
      decision_t d;
      np = eff_procs();
      nr = eff_res();
      count = 0;
      if (p >= np) begin
         decision_out.push_back(lone(STAT_EXCEED));
         return;
      end
      // resource order: exceed check before wait check per resource
      for (int j = 0; j < nr; j++) begin
         if (req_vec[j] > need_of(p, j)) begin
            decision_out.push_back(lone(STAT_EXCEED));
            return;
         end
         if (req_vec[j] > avail_vec[j]) begin
            decision_out.push_back(lone(STAT_WAIT));
            return;
         end
      end
      // tentative grant
      for (int j = 0; j < nr; j++) begin
         avail_vec[j] -= req_vec[j];
         alloc_mat[p][j] = (alloc_mat[p][j] + req_vec[j]) & 8'hFF;
         work[j] = avail_vec[j];
      end
      for (int i = 0; i < NPROC; i++) done[i] = 0;
      // repeated forward scans until a round finds nobody
      while (count < np) begin
         found = 0;
         for (int i = 0; i < np; i++) begin
            if (done[i]) continue;
            fits = 1;
            for (int j = 0; j < nr; j++)
               if (need_of(i, j) > work[j]) fits = 0;
            if (fits) begin
               for (int j = 0; j < nr; j++) begin
                  work[j] = work[j] + alloc_mat[i][j];
                  if (work[j] > WORK_MAX) work[j] = WORK_MAX;
               end
               done[i] = 1;
               order[count] = i;
               count++;
               found = 1;
            end
         end
         if (!found) break;
      end
      if (count == np) begin
         for (int i = 0; i < np; i++) begin
            d.status = STAT_GRANT;
            d.seq_proc = order[i][2:0];
            d.last = (i + 1 == np);
            decision_out.push_back(d);
         end
         return;
      end
      // unsafe: roll the tentative grant back
      for (int j = 0; j < nr; j++) begin
         avail_vec[j] += req_vec[j];
         alloc_mat[p][j] = (alloc_mat[p][j] - req_vec[j]) & 8'hFF;
      end
      decision_out.push_back(lone(STAT_UNSAFE));
   endtask

   task automatic apply_item(op_type op, int p, int r, int amt, bit last);
      decision_out.delete();
      case (op)
         OP_LOAD_ALLOC: alloc_mat[p][r] = amt;
         OP_LOAD_MAX:   max_mat[p][r] = amt;
         OP_LOAD_AVAIL: avail_vec[r] = amt;
         default: begin
            req_vec[r] = amt;
            if (last) run_decision(p);
         end
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------------
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   task automatic send_item(op_type op, int p, int r, int amt, bit last,
                            bit typed = 0, status_type st = STAT_GRANT);
      int gap;
      gap = pick_gap();
      if (gap > 0 && req_ch.valid) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.opcode <= op;
      req_ch.process_index <= p[2:0];
      req_ch.resource_index <= r[1:0];
      req_ch.amount <= amt[7:0];
      req_ch.last_element <= last;
      do @(posedge clock); while (!req_ch.ready);
      // transfer taken at this edge
      apply_item(op, p, r, amt, last);
      if (typed && decision_out.size() > 0) begin
         pending_results.push_back(lone(st));
      end else begin
         foreach (decision_out[k]) pending_results.push_back(decision_out[k]);
      end
   endtask

   // Stop offering, wait for all results, then let trailing work settle.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pending_results.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(csr_type idx, int val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_NUM_PROCS) cfg_procs = val & 15;
      else cfg_res = val & 7;
   endtask

   task automatic load_all_small();
      for (int p = 0; p < NPROC; p++) begin
         for (int r = 0; r < NRES; r++) begin
            send_item(OP_LOAD_ALLOC, p, r, $urandom_range(2), 0);
            send_item(OP_LOAD_MAX, p, r, alloc_mat[p][r] + $urandom_range(3), 0);
         end
      end
      for (int r = 0; r < NRES; r++) send_item(OP_LOAD_AVAIL, 0, r, $urandom_range(8, 3), 0);
   endtask

   // Random loads, request sequences and noise until n_items are sent; mostly well-formed.
   task automatic random_traffic(int n_items);
      int sent, roll, nr, p;
      sent = 0;
      while (sent < n_items) begin
         roll = $urandom_range(99);
         if (roll < 55) begin
            nr = ($urandom_range(3) == 0) ? NRES : eff_res();
            p = $urandom_range(NPROC - 1);
            for (int r = 0; r < nr; r++) begin
               send_item(OP_REQUEST, p, r,
                         ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(2),
                         r == nr - 1);
               sent++;
            end
         end else if (roll < 85) begin
            p = $urandom_range(NPROC - 1);
            case ($urandom_range(2))
               0: send_item(OP_LOAD_ALLOC, p, $urandom_range(3), $urandom_range(2), 0);
               1: send_item(OP_LOAD_MAX, p, $urandom_range(3), $urandom_range(5), 0);
               default: send_item(OP_LOAD_AVAIL, p, $urandom_range(3), $urandom_range(8), 0);
            endcase
            sent++;
         end else begin
            // noise: any field value, any opcode
            send_item(op_type'($urandom_range(3)), $urandom_range(7), $urandom_range(3),
                      $urandom_range(255), $urandom_range(1));
            sent++;
         end
      end
   endtask

   stim_row_t dir_table [$];

   task automatic add_row(op_type op, int p, int r, int amt, bit last,
                          bit typed = 0, status_type st = STAT_GRANT);
      stim_row_t row;
      row.op = op; row.proc = p; row.res = r; row.amt = amt; row.last = last;
      row.typed = typed; row.status = st;
      dir_table.push_back(row);
   endtask

   initial begin
      int procs_set [6] = '{8, 0, 15, 3, 1, 5};
      int res_set [6] = '{4, 1, 0, 2, 7, 3};

      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_NUM_PROCS;
      csr_wdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.opcode <= OP_LOAD_ALLOC;
      req_ch.process_index <= '0;
      req_ch.resource_index <= '0;
      req_ch.amount <= '0;
      req_ch.last_element <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill every matrix entry so no decision reads an unwritten cell.
      for (int p = 0; p < NPROC; p++) begin
         for (int r = 0; r < NRES; r++) begin
            send_item(OP_LOAD_ALLOC, p, r, 1, 0);
            send_item(OP_LOAD_MAX, p, r, 3, 0);
         end
      end
      for (int r = 0; r < NRES; r++) send_item(OP_LOAD_AVAIL, 0, r, 4, 0);

      // Directed rows. Need is 2 everywhere, available 4.
      for (int r = 0; r < NRES; r++) add_row(OP_REQUEST, 0, r, 1, r == NRES - 1);
      // full-scale request exceeds need on resource 0
      add_row(OP_REQUEST, 7, 0, 255, 1, 1, STAT_EXCEED);
      add_row(OP_REQUEST, 7, 0, 0, 0);
      // no stock of resource 0 left: must wait
      add_row(OP_LOAD_AVAIL, 0, 0, 0, 0);
      add_row(OP_REQUEST, 1, 0, 1, 1, 1, STAT_WAIT);
      // zero request with nothing available: nobody can finish
      for (int r = 0; r < NRES; r++) add_row(OP_LOAD_AVAIL, 0, r, 0, 0);
      for (int r = 0; r < NRES; r++) add_row(OP_REQUEST, 2, r, 0, r == NRES - 1, 1, STAT_UNSAFE);
      // full-scale counts: grant expected
      for (int r = 0; r < NRES; r++) add_row(OP_LOAD_AVAIL, 7, r, 255, 0);
      add_row(OP_LOAD_MAX, 7, 3, 255, 0);
      add_row(OP_LOAD_ALLOC, 7, 3, 0, 0);
      add_row(OP_REQUEST, 7, 3, 200, 1);

      foreach (dir_table[i])
         send_item(dir_table[i].op, dir_table[i].proc, dir_table[i].res, dir_table[i].amt,
                   dir_table[i].last, dir_table[i].typed, dir_table[i].status);

      // Random phases over several register settings, extremes included.
      for (int ph = 0; ph < 6; ph++) begin
         drain();
         write_csr(CSR_NUM_PROCS, (ph == 5) ? $urandom_range(15) : procs_set[ph]);
         write_csr(CSR_NUM_RES, (ph == 5) ? $urandom_range(7) : res_set[ph]);
         if (ph == 0) load_all_small();
         if (ph == 2) hold_off_req = 1;   // receiver stalls long while we keep sending
         random_traffic(40);
      end

      drain();
      if (errors == 0) begin
         $display("PASS bankers_safety_check_core");
      end else begin
         $display("FAIL bankers_safety_check_core");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Receiver side: check each result transfer, then pick next ready.
   // ------------------------------------------------------------------------
   initial begin
      int stall_left;
      decision_t want;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t unexpected result: status %0d seq %0d last %0b", $time,
                        rsp_ch.status, rsp_ch.sequence_process, rsp_ch.last);
               errors++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_ch.status !== want.status) begin
                  $display("%0t status: expected %0d actual %0d", $time, want.status,
                           rsp_ch.status);
                  errors++;
               end
               if (rsp_ch.sequence_process !== want.seq_proc) begin
                  $display("%0t sequence_process: expected %0d actual %0d", $time,
                           want.seq_proc, rsp_ch.sequence_process);
                  errors++;
               end
               if (rsp_ch.last !== want.last) begin
                  $display("%0t last: expected %0b actual %0b", $time, want.last,
                           rsp_ch.last);
                  errors++;
               end
            end
         end
         if (hold_off_req) begin
            hold_off_req = 0;
            stall_left = 600;   // long hold-off: core fills and backs up req_ch
         end else if (stall_left == 0) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

endmodule
